// ===== src/kvtt_pkg.sv =====
// Shared types and constants of the key/value text tokenizer.
package kvtt_pkg;

  // Width of every reported offset and length.
  localparam int unsigned FIELD_W = 16;

  // Delimiter characters.
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // Blank characters: tab, LF, VT, FF, CR and space.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Parser states.
  typedef enum logic [4:0] {
    ST_SKIP  = 5'b00001,
    ST_KEY   = 5'b00010,
    ST_VALUE = 5'b00100,
    ST_LIST  = 5'b01000,
    ST_CLOSE = 5'b10000
  } kvtt_state_t;

  // One completed key/value pair.
  typedef struct packed {
    logic [FIELD_W-1:0] value_length;
    logic [FIELD_W-1:0] value_start;
    logic [FIELD_W-1:0] key_length;
    logic [FIELD_W-1:0] key_start;
  } kvtt_result_t;

  // True for the blank characters.
  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== src/kvtt_core.sv =====
// Parser state registers and the per-byte next-state and pair-report logic.
module kvtt_core #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            text_byte,
  input  logic                  end_of_text,
  output logic                  res_valid,
  output kvtt_pkg::kvtt_result_t res
);
  import kvtt_pkg::*;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  kvtt_state_t         state_r, state_nxt;
  kvtt_state_t         resume_r, resume_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] tok_r, tok_nxt;
  logic [POS_BITS:0]   lnb_r, lnb_nxt;
  logic [POS_BITS-1:0] hks_r, hks_nxt;
  logic [POS_BITS-1:0] hkl_r, hkl_nxt;
  logic [POS_BITS-1:0] hvs_r, hvs_nxt;
  logic [POS_BITS-1:0] hvl_r, hvl_nxt;
  logic                blank;
  logic                emit;
  kvtt_state_t         st;

  // Trimmed token length: zero when no non-blank byte was seen, saturated at the top.
  function automatic logic [POS_BITS-1:0] tok_len(input logic [POS_BITS:0] lnb,
                                                  input logic [POS_BITS-1:0] tok);
    logic [POS_BITS:0] diff;
    diff = lnb - {1'b0, tok};
    if (lnb <= {1'b0, tok}) begin
      tok_len = '0;
    end else if (diff[POS_BITS]) begin
      tok_len = POS_MAX;
    end else begin
      tok_len = diff[POS_BITS-1:0];
    end
  endfunction

  // Next state for one byte.
  always_comb begin
    blank      = is_blank(text_byte);
    emit       = 1'b0;
    st         = state_r;
    resume_nxt = resume_r;
    tok_nxt    = tok_r;
    lnb_nxt    = lnb_r;
    hks_nxt    = hks_r;
    hkl_nxt    = hkl_r;
    hvs_nxt    = hvs_r;
    hvl_nxt    = hvl_r;
    pos_nxt    = pos_r;

    // Leading blanks are skipped; the first non-blank byte opens a token.
    if (!(st == ST_KEY || st == ST_VALUE || st == ST_LIST || st == ST_CLOSE)) begin
      st = ST_SKIP;
      if (!blank) begin
        tok_nxt = pos_r;
        lnb_nxt = {1'b0, pos_r};
        st      = resume_r;
      end
    end

    // Token body.
    unique case (st)
      ST_KEY: begin
        if (text_byte == CH_COLON) begin
          hks_nxt    = tok_nxt;
          hkl_nxt    = tok_len(lnb_nxt, tok_nxt);
          st         = ST_SKIP;
          resume_nxt = ST_VALUE;
        end else if (!blank) begin
          lnb_nxt = {1'b0, pos_r} + 1'b1;
        end
      end
      ST_VALUE: begin
        if (text_byte == CH_LBRACK) begin
          st         = ST_SKIP;
          resume_nxt = ST_LIST;
        end else if (text_byte == CH_COMMA) begin
          hvs_nxt    = tok_nxt;
          hvl_nxt    = tok_len(lnb_nxt, tok_nxt);
          emit       = 1'b1;
          st         = ST_SKIP;
          resume_nxt = ST_KEY;
        end else if (!blank) begin
          lnb_nxt = {1'b0, pos_r} + 1'b1;
        end
      end
      ST_LIST: begin
        if (text_byte == CH_RBRACK) begin
          hvs_nxt = tok_nxt;
          hvl_nxt = tok_len(lnb_nxt, tok_nxt);
          st      = ST_CLOSE;
        end else if (!blank) begin
          lnb_nxt = {1'b0, pos_r} + 1'b1;
        end
      end
      ST_CLOSE: begin
        if (text_byte == CH_COMMA) begin
          emit       = 1'b1;
          st         = ST_SKIP;
          resume_nxt = ST_KEY;
        end
      end
      default: begin
      end
    endcase

    // End of text flushes a pending pair.
    if (end_of_text) begin
      if (st == ST_VALUE) begin
        hvs_nxt = tok_nxt;
        hvl_nxt = tok_len(lnb_nxt, tok_nxt);
        emit    = 1'b1;
      end else if (st == ST_CLOSE) begin
        emit = 1'b1;
      end
    end

    res.key_start    = FIELD_W'(hks_nxt);
    res.key_length   = FIELD_W'(hkl_nxt);
    res.value_start  = FIELD_W'(hvs_nxt);
    res.value_length = FIELD_W'(hvl_nxt);
    res_valid        = emit;

    // After the flush everything returns to its reset value.
    if (end_of_text) begin
      st         = ST_SKIP;
      resume_nxt = ST_KEY;
      pos_nxt    = '0;
      tok_nxt    = '0;
      lnb_nxt    = '0;
      hks_nxt    = '0;
      hkl_nxt    = '0;
      hvs_nxt    = '0;
      hvl_nxt    = '0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
    end
    state_nxt = st;
  end

  // State registers advance on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_SKIP;
      resume_r <= ST_KEY;
      pos_r    <= '0;
      tok_r    <= '0;
      lnb_r    <= '0;
      hks_r    <= '0;
      hkl_r    <= '0;
      hvs_r    <= '0;
      hvl_r    <= '0;
    end else if (step_en) begin
      state_r  <= state_nxt;
      resume_r <= resume_nxt;
      pos_r    <= pos_nxt;
      tok_r    <= tok_nxt;
      lnb_r    <= lnb_nxt;
      hks_r    <= hks_nxt;
      hkl_r    <= hkl_nxt;
      hvs_r    <= hvs_nxt;
      hvl_r    <= hvl_nxt;
    end
  end

  // A finished text leaves the parser at offset zero, skipping blanks for a key.
  a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && end_of_text |=> pos_r == '0 && state_r == ST_SKIP && resume_r == ST_KEY)
    else $error("parser did not restart after end of text");

  // The position counts up by one per byte until it saturates.
  a_pos_count: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !end_of_text && pos_r != POS_MAX |=> pos_r == $past(pos_r) + 1'b1)
    else $error("byte position did not advance");

  // The end marker never runs more than one byte past the current position.
  a_lnb_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lnb_r <= {1'b0, pos_r} + 1'b1)
    else $error("last non-blank mark ahead of position");

endmodule

// ===== src/key_value_text_tokenizer.sv =====
// Top level of the key/value text tokenizer: parser core and output skid buffer.
//
//  Channel | Direction | Request
//  in_     | slave     | tdata: text_byte[7:0]; tlast: end_of_text
//  out_    | master    | tdata: key_start, key_length, value_start, value_length (16 b each)
//
// One byte per cycle is taken while the skid entry is free; each completed pair is registered.
// The whole parse step is one pass of logic from the byte into the state and result registers.
// Synchronous active-low reset returns the parser to offset 0, looking for a key.
// A two-entry output buffer keeps input flowing while one result waits; input stalls
// only when both entries hold results that the sink has not taken.
module key_value_text_tokenizer #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [15:0] key_start, [31:16] key_length,
                                  // [47:32] value_start, [63:48] value_length
);
  import kvtt_pkg::*;

  logic         accept_in;
  logic         res_valid;
  kvtt_result_t res;
  logic         new_res;
  logic         out_take;
  logic         out_valid_r, out_valid_nxt;
  kvtt_result_t out_data_r, out_data_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  kvtt_result_t skid_data_r, skid_data_nxt;

  assign in_tready = !skid_valid_r;
  assign accept_in = in_tvalid && in_tready;

  kvtt_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (accept_in),
    .text_byte   (in_tdata),
    .end_of_text (in_tlast),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign new_res  = accept_in && res_valid;
  assign out_take = out_valid_r && out_tready;

  // Output register with one skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (new_res) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (new_res) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The skid entry is only used behind a full output register.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result ahead of the output register");

  // A result that arrives while the output is stalled lands in the skid entry.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    new_res && out_valid_r && !out_tready |=> skid_valid_r && skid_data_r == $past(res))
    else $error("result lost while output stalled");

  // A waiting skid result moves forward as soon as the output is taken.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_tready |=> out_valid_r && out_data_r == $past(skid_data_r))
    else $error("skid result not forwarded");

endmodule
